### rtl/core/cpe_pkg.sv
// shared types and codes of the copy-paste edit distance core
`default_nettype none

package cpe_pkg;

  localparam logic [1:0] ACT_SRC = 2'd0;
  localparam logic [1:0] ACT_TGT = 2'd1;
  localparam logic [1:0] ACT_RUN = 2'd2;
  // unused code: the item is taken and ignored
  localparam logic [1:0] ACT_NOP = 2'd3;

  localparam int unsigned DIST_W   = 9;
  localparam int unsigned DIST_SAT = 511;
  localparam int unsigned LIM_W    = 6;
  localparam logic [LIM_W-1:0] COPY_LIMIT_RESET = 6'd20;

  typedef struct packed {
    logic load_src;
    logic load_tgt;
    logic start;
    logic mj_rd;
    logic mj_lat;
    logic me_rd;
    logic me_calc;
    logic mj_wr;
    logic r_start;
    logic d_rd;
    logic d_base;
    logic d_copy;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic tgt_empty;
    logic j_one;
    logic j_last;
    logic e_one;
    logic rows_done;
    logic mask_zero;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

### rtl/core/cpe_ram.sv
// generic single-write single-read ram with registered read data
`default_nettype none

module cpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                           wdata_i,
  input  wire logic                                       re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/cpe_ctrl.sv
// controller state machine: sequences loads, copy-mask build and table fill
`default_nettype none

module cpe_ctrl import cpe_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] action_i,
  input  wire sts_t       sts_i,
  output cmd_t            cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MJ_RD   = 4'd1;
  localparam logic [3:0] S_MJ_LAT  = 4'd2;
  localparam logic [3:0] S_ME_RD   = 4'd3;
  localparam logic [3:0] S_ME_CALC = 4'd4;
  localparam logic [3:0] S_MJ_WR   = 4'd5;
  localparam logic [3:0] S_R_START = 4'd6;
  localparam logic [3:0] S_D_RD    = 4'd7;
  localparam logic [3:0] S_D_BASE  = 4'd8;
  localparam logic [3:0] S_D_COPY  = 4'd9;
  localparam logic [3:0] S_FINISH  = 4'd10;

  logic [3:0] state_q, state_d;
  logic       accept;

  // a compute item waits while the previous result is still held
  assign in_ready_o = (state_q == S_IDLE) && !((action_i == ACT_RUN) && sts_i.out_busy);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load_src = accept && (action_i == ACT_SRC);
    cmd_o.load_tgt = accept && (action_i == ACT_TGT);
    cmd_o.start    = accept && (action_i == ACT_RUN);
    cmd_o.mj_rd    = (state_q == S_MJ_RD);
    cmd_o.mj_lat   = (state_q == S_MJ_LAT);
    cmd_o.me_rd    = (state_q == S_ME_RD);
    cmd_o.me_calc  = (state_q == S_ME_CALC);
    cmd_o.mj_wr    = (state_q == S_MJ_WR);
    cmd_o.r_start  = (state_q == S_R_START);
    cmd_o.d_rd     = (state_q == S_D_RD);
    cmd_o.d_base   = (state_q == S_D_BASE);
    cmd_o.d_copy   = (state_q == S_D_COPY);
    cmd_o.finish   = (state_q == S_FINISH);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.start) begin
          state_d = sts_i.tgt_empty ? S_R_START : S_MJ_RD;
        end
      end
      S_MJ_RD:   state_d = S_MJ_LAT;
      S_MJ_LAT:  state_d = sts_i.j_one ? S_MJ_WR : S_ME_RD;
      S_ME_RD:   state_d = S_ME_CALC;
      S_ME_CALC: state_d = sts_i.e_one ? S_MJ_WR : S_ME_RD;
      S_MJ_WR:   state_d = sts_i.j_last ? S_R_START : S_MJ_RD;
      S_R_START: begin
        if (sts_i.rows_done) begin
          state_d = S_FINISH;
        end else if (!sts_i.tgt_empty) begin
          state_d = S_D_RD;
        end
      end
      S_D_RD:    state_d = S_D_BASE;
      S_D_BASE:  state_d = S_D_COPY;
      S_D_COPY: begin
        if (sts_i.mask_zero) begin
          state_d = sts_i.j_last ? S_R_START : S_D_RD;
        end
      end
      S_FINISH:  state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/cpe_datapath.sv
// datapath: string stores, copy-mask builder, row table and result register
`default_nettype none

module cpe_datapath import cpe_pkg::*; #(
  parameter int MAX_LEN  = 256,
  parameter int MAX_COPY = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  output sts_t                   sts_o,
  input  wire logic [7:0]        symbol_i,
  input  wire logic              cfg_we_i,
  input  wire logic [LIM_W-1:0]  cfg_wdata_i,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic [DIST_W-1:0]      distance_o,
  output logic                   overflow_o
);

  localparam int LW  = $clog2(MAX_LEN + 1);
  localparam int IW  = $clog2(MAX_LEN + 2);
  localparam int TAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int DW  = $clog2(2 * MAX_LEN + 3);
  localparam int CW  = $clog2(MAX_COPY + 1);
  localparam int KW  = (MAX_COPY > 1) ? $clog2(MAX_COPY) : 1;

  logic [LW-1:0]       src_len_q, tgt_len_q;
  logic                ovf_q;
  logic [LIM_W-1:0]    lim_q;
  logic [LW-1:0]       j_q, e_q;
  logic [IW-1:0]       i_q;
  logic                out_valid_q;

  logic [7:0]          tj_q;
  logic [MAX_COPY-1:0] acc_q, mask_q;
  logic                lz_q, row0_q;
  logic [DW-1:0]       diag_q, best_q, dm_old_q;
  logic [KW-1:0]       k_q;
  logic [DW-1:0]       tap_q [MAX_COPY];
  logic [DIST_W-1:0]   dist_q;
  logic                out_ovf_q;

  logic [7:0]          src_rd, tgt_rd;
  logic [CW-1:0]       lcs_rd;
  logic [DW-1:0]       row_rd, dm_rd;
  logic [MAX_COPY-1:0] mask_rd;

  logic                src_full, tgt_full;
  logic                tgt_re;
  logic [TAW-1:0]      tgt_raddr;
  logic [CW-1:0]       lim_eff, top_len, lcs_prev, lcs_new, run_len;
  logic [LW-1:0]       half_j, gap;
  logic [MAX_COPY-1:0] th_run, th_top;
  logic [DW-1:0]       cand_diag, cand_ins, base, cand_cp, best_inc, new_dm, cur0;

  assign src_full = (src_len_q == LW'(MAX_LEN));
  assign tgt_full = (tgt_len_q == LW'(MAX_LEN));

  // ---------------- stores ----------------
  cpe_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_src_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_src && !src_full),
    .waddr_i (TAW'(src_len_q)),
    .wdata_i (symbol_i),
    .re_i    (cmd_i.r_start && !sts_o.rows_done),
    .raddr_i (TAW'(i_q - IW'(1))),
    .rdata_o (src_rd)
  );

  always_comb begin
    tgt_re    = cmd_i.mj_rd || cmd_i.me_rd || cmd_i.d_rd;
    tgt_raddr = TAW'(j_q - LW'(1));
    if (cmd_i.me_rd) begin
      tgt_raddr = TAW'(e_q - LW'(1));
    end
  end

  cpe_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_tgt_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_tgt && !tgt_full),
    .waddr_i (TAW'(tgt_len_q)),
    .wdata_i (symbol_i),
    .re_i    (tgt_re),
    .raddr_i (tgt_raddr),
    .rdata_o (tgt_rd)
  );

  // common suffix lengths of the previous column, updated in place top down
  cpe_ram #(.WIDTH(CW), .DEPTH(MAX_LEN)) u_lcs_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.me_calc),
    .waddr_i (TAW'(e_q)),
    .wdata_i (lcs_new),
    .re_i    (cmd_i.me_rd),
    .raddr_i (TAW'(e_q - LW'(1))),
    .rdata_o (lcs_rd)
  );

  cpe_ram #(.WIDTH(MAX_COPY), .DEPTH(MAX_LEN + 1)) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mj_wr),
    .waddr_i (j_q),
    .wdata_i (acc_q & th_top),
    .re_i    (cmd_i.d_rd),
    .raddr_i (j_q),
    .rdata_o (mask_rd)
  );

  cpe_ram #(.WIDTH(DW), .DEPTH(MAX_LEN + 1)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.d_copy && sts_o.mask_zero),
    .waddr_i (j_q),
    .wdata_i (best_q),
    .re_i    (cmd_i.d_rd),
    .raddr_i (j_q),
    .rdata_o (row_rd)
  );

  cpe_ram #(.WIDTH(DW), .DEPTH(MAX_LEN + 1)) u_dm_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.d_copy && sts_o.mask_zero),
    .waddr_i (j_q),
    .wdata_i (new_dm),
    .re_i    (cmd_i.d_rd),
    .raddr_i (j_q),
    .rdata_o (dm_rd)
  );

  // ---------------- copy mask logic ----------------
  assign lim_eff = (32'(lim_q) > 32'(MAX_COPY)) ? CW'(MAX_COPY) : CW'(lim_q);
  assign half_j  = j_q >> 1;
  assign top_len = (32'(half_j) < 32'(lim_eff)) ? CW'(half_j) : lim_eff;

  assign lcs_prev = lz_q ? '0 : lcs_rd;
  always_comb begin
    lcs_new = '0;
    if (tgt_rd == tj_q) begin
      lcs_new = (lcs_prev == CW'(MAX_COPY)) ? lcs_prev : lcs_prev + CW'(1);
    end
  end
  assign gap     = j_q - e_q;
  assign run_len = (32'(gap) < 32'(lcs_new)) ? CW'(gap) : lcs_new;

  always_comb begin
    for (int b = 0; b < MAX_COPY; b++) begin
      th_run[b] = (32'(b) < 32'(run_len));
      th_top[b] = (32'(b) < 32'(top_len));
    end
  end

  // ---------------- cell arithmetic ----------------
  assign cand_diag = diag_q + DW'(src_rd != tgt_rd);
  assign cand_ins  = tap_q[0] + DW'(1);
  always_comb begin
    base = cand_ins;
    if (!row0_q) begin
      if (cand_diag < base) base = cand_diag;
      if (dm_rd < base)     base = dm_rd;
    end
  end
  assign cand_cp  = tap_q[k_q] + DW'(1);
  assign best_inc = best_q + DW'(1);
  assign new_dm   = (row0_q || best_inc < dm_old_q) ? best_inc : dm_old_q;
  assign cur0     = (i_q == '0) ? DW'(0) : DW'(1);

  // ---------------- status ----------------
  always_comb begin
    sts_o           = '0;
    sts_o.tgt_empty = (tgt_len_q == '0);
    sts_o.j_one     = (j_q == LW'(1));
    sts_o.j_last    = (j_q == tgt_len_q);
    sts_o.e_one     = (e_q == LW'(1));
    sts_o.rows_done = (32'(i_q) == 32'(src_len_q) + 32'd1);
    sts_o.mask_zero = (mask_q == '0);
    sts_o.out_busy  = out_valid_q;
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_len_q   <= '0;
      tgt_len_q   <= '0;
      ovf_q       <= 1'b0;
      lim_q       <= COPY_LIMIT_RESET;
      j_q         <= '0;
      e_q         <= '0;
      i_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lim_q <= cfg_wdata_i;
      end
      if (cmd_i.load_src) begin
        if (src_full) ovf_q <= 1'b1;
        else          src_len_q <= src_len_q + LW'(1);
      end
      if (cmd_i.load_tgt) begin
        if (tgt_full) ovf_q <= 1'b1;
        else          tgt_len_q <= tgt_len_q + LW'(1);
      end
      if (cmd_i.start) begin
        j_q <= LW'(1);
        i_q <= '0;
      end
      if (cmd_i.mj_rd) begin
        e_q <= j_q - LW'(1);
      end
      if (cmd_i.me_calc) begin
        e_q <= e_q - LW'(1);
      end
      if (cmd_i.mj_wr && !sts_o.j_last) begin
        j_q <= j_q + LW'(1);
      end
      if (cmd_i.r_start && !sts_o.rows_done) begin
        j_q <= LW'(1);
        i_q <= i_q + IW'(1);
      end
      if (cmd_i.d_copy && sts_o.mask_zero && !sts_o.j_last) begin
        j_q <= j_q + LW'(1);
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        src_len_q   <= '0;
        tgt_len_q   <= '0;
        ovf_q       <= 1'b0;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.mj_lat) begin
      tj_q  <= tgt_rd;
      acc_q <= '0;
    end
    if (cmd_i.me_rd) begin
      lz_q <= (e_q == LW'(1));
    end
    if (cmd_i.me_calc) begin
      acc_q <= acc_q | th_run;
    end
    if (cmd_i.r_start && !sts_o.rows_done) begin
      row0_q <= (i_q == '0);
      // previous row's column zero feeds the first diagonal
      diag_q <= (i_q <= IW'(1)) ? DW'(0) : DW'(1);
      tap_q[0] <= cur0;
      for (int b = 1; b < MAX_COPY; b++) begin
        tap_q[b] <= tap_q[b-1];
      end
    end
    if (cmd_i.d_base) begin
      best_q   <= base;
      mask_q   <= mask_rd;
      k_q      <= '0;
      dm_old_q <= dm_rd;
      diag_q   <= row_rd;
    end
    if (cmd_i.d_copy) begin
      if (mask_q == '0) begin
        tap_q[0] <= best_q;
        for (int b = 1; b < MAX_COPY; b++) begin
          tap_q[b] <= tap_q[b-1];
        end
      end else begin
        if (mask_q[0] && (cand_cp < best_q)) begin
          best_q <= cand_cp;
        end
        mask_q <= mask_q >> 1;
        k_q    <= k_q + KW'(1);
      end
    end
    if (cmd_i.finish) begin
      dist_q    <= (32'(tap_q[0]) > 32'(DIST_SAT)) ? DIST_W'(DIST_SAT) : DIST_W'(tap_q[0]);
      out_ovf_q <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = dist_q;
  assign overflow_o  = out_ovf_q;

endmodule

`default_nettype wire

### rtl/core/copy_paste_edit_distance_core.sv
// top level of the copy-paste edit distance core
// input channel: valid/ready with action_i and symbol_i. action 0 appends
// symbol_i to the source string, 1 appends it to the target string, 2 runs
// the distance and then clears both strings and the overflow flag.
// a load item appends one byte and loads can follow back to back; a byte
// beyond MAX_LEN is dropped and flagged on the next result.
// a compute item first builds one copy mask per target column with a shared
// suffix-compare unit.
// the table is then filled one cell at a time, row by row over n+1 rows for a
// source of length n, from row memories with one write and one read port; each
// cell tries the allowed copy lengths of its column, then the result is posted.
// output channel: valid/ready with distance_o and overflow_o from a result
// register; loads are still taken while a result waits, a compute item waits.
// cfg_we_i writes copy_limit from cfg_wdata_i; write it only while idle.
// reset (rst_ni low, asynchronous) empties both strings, clears the flag
// and sets copy_limit to 20.
`default_nettype none

module copy_paste_edit_distance_core import cpe_pkg::*; #(
  parameter int MAX_LEN  = 256,
  parameter int MAX_COPY = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        action_i,
  input  wire logic [7:0]        symbol_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [DIST_W-1:0]      distance_o,
  output logic                   overflow_o,
  input  wire logic              cfg_we_i,
  input  wire logic [LIM_W-1:0]  cfg_wdata_i
);

  cmd_t cmd;
  sts_t sts;

  cpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cpe_datapath #(
    .MAX_LEN  (MAX_LEN),
    .MAX_COPY (MAX_COPY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .symbol_i    (symbol_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .distance_o  (distance_o),
    .overflow_o  (overflow_o)
  );

endmodule

`default_nettype wire

### bench/cpe_scoreboard.sv
// checker for the copy-paste edit distance core: predicts each distance and compares
module cpe_scoreboard import cpe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [1:0]        action_i,
  input  logic [7:0]        symbol_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [DIST_W-1:0] distance_i,
  input  logic              overflow_i,
  input  logic              cfg_we_i,
  input  logic [LIM_W-1:0]  cfg_wdata_i,
  output int                errors_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StrMax  = 256;
  localparam int CopyMax = 32;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } result_t;

  logic [7:0]       src_text[$];
  logic [7:0]       tgt_text[$];
  logic             dropped;
  logic [LIM_W-1:0] copy_limit;
  result_t          distance_fifo[$];

  function automatic int predict_distance(input int lim_in);
    logic [31:0] copy_ok[0:StrMax];
    int cur[0:StrMax];
    int prev[0:StrMax];
    int del_min[0:StrMax];
    int n, m, lim, top, start, best, sub;
    bit hit, same;
    n = src_text.size();
    m = tgt_text.size();
    lim = (lim_in > CopyMax) ? CopyMax : lim_in;
    // one mask per column: bit len-1 set when the suffix of that length appears earlier
    for (int j = 0; j <= m; j++) begin
      top = (j / 2 < lim) ? j / 2 : lim;
      copy_ok[j] = '0;
      for (int len = 1; len <= top; len++) begin
        start = j - len;
        hit = 0;
        for (int s = 0; s + len <= start && !hit; s++) begin
          same = 1;
          for (int k = 0; k < len; k++)
            if (tgt_text[s+k] != tgt_text[start+k]) same = 0;
          hit = same;
        end
        if (hit) copy_ok[j][len-1] = 1'b1;
      end
    end
    cur[0] = 0;
    del_min[0] = 1;
    for (int j = 1; j <= m; j++) begin
      best = cur[j-1] + 1;
      for (int len = 1; len <= CopyMax && len <= j; len++)
        if (copy_ok[j][len-1] && cur[j-len] + 1 < best) best = cur[j-len] + 1;
      cur[j] = best;
      del_min[j] = best + 1;
    end
    for (int i = 1; i <= n; i++) begin
      prev = cur;
      cur[0] = del_min[0];
      if (cur[0] + 1 < del_min[0]) del_min[0] = cur[0] + 1;
      for (int j = 1; j <= m; j++) begin
        sub = (src_text[i-1] == tgt_text[j-1]) ? 0 : 1;
        best = prev[j-1] + sub;
        if (cur[j-1] + 1 < best) best = cur[j-1] + 1;
        if (del_min[j] < best) best = del_min[j];
        for (int len = 1; len <= CopyMax && len <= j; len++)
          if (copy_ok[j][len-1] && cur[j-len] + 1 < best) best = cur[j-len] + 1;
        cur[j] = best;
        if (best + 1 < del_min[j]) del_min[j] = best + 1;
      end
    end
    return (cur[m] > DIST_SAT) ? DIST_SAT : cur[m];
  endfunction

  assign pending_o = distance_fifo.size();

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      src_text.delete();
      tgt_text.delete();
      distance_fifo.delete();
      dropped    <= 1'b0;
      copy_limit <= COPY_LIMIT_RESET;
      errors_o   <= 0;
    end else begin
      if (cfg_we_i) copy_limit <= cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        case (action_i)
          ACT_SRC: begin
            if (src_text.size() < StrMax) src_text.insert(src_text.size(), symbol_i);
            else dropped <= 1'b1;
          end
          ACT_TGT: begin
            if (tgt_text.size() < StrMax) tgt_text.insert(tgt_text.size(), symbol_i);
            else dropped <= 1'b1;
          end
          ACT_RUN: begin
            want.distance = DIST_W'(predict_distance(int'(copy_limit)));
            want.overflow = dropped;
            distance_fifo.insert(distance_fifo.size(), want);
            src_text.delete();
            tgt_text.delete();
            dropped <= 1'b0;
          end
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (distance_fifo.size() == 0) begin
          if (errors_o < 10)
            $display("unexpected result: distance %0d overflow %0b", distance_i, overflow_i);
          errors_o <= errors_o + 1;
        end else begin
          want = distance_fifo.pop_front();
          if (distance_i !== want.distance || overflow_i !== want.overflow) begin
            if (errors_o < 10)
              $display("mismatch: distance %0d/%0d overflow %0b/%0b (expected/actual)",
                       want.distance, distance_i, want.overflow, overflow_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end
endmodule

### bench/tb_copy_paste_edit_distance_core.sv
// stimulus and verdict for the copy-paste edit distance core
module tb_copy_paste_edit_distance_core import cpe_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit = 400000;
  localparam int ItemTarget = 1450;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        action;
  logic [7:0]        symbol;
  logic              out_valid;
  logic              out_ready;
  logic [DIST_W-1:0] distance;
  logic              overflow;
  logic              cfg_we;
  logic [LIM_W-1:0]  cfg_wdata;
  int                errors;
  int                pending;
  int                item_count;
  int                quiet_cycles;
  int                out_stall;

  copy_paste_edit_distance_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .action_i    (action),
    .symbol_i    (symbol),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .distance_o  (distance),
    .overflow_o  (overflow),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  cpe_scoreboard i_scoreboard (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .action_i    (action),
    .symbol_i    (symbol),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .distance_i  (distance),
    .overflow_i  (overflow),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // receiver stalls: mostly ready, sometimes short stalls, rarely long ones
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_ready <= 1'b1;
      out_stall <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [1:0] act, input logic [7:0] sym);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    symbol   <= sym;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    item_count++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // a dropped load or stray item may still be in flight
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIM_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_string(input logic [1:0] act, input int len, input logic [7:0] base);
    for (int k = 0; k < len; k++) send_item(act, base + 8'($urandom_range(0, 1)));
  endtask

  // one well-formed job with random content, sizes kept small
  task automatic send_job();
    int n, m, wide;
    logic [7:0] base;
    n = $urandom_range(0, 10);
    m = $urandom_range(0, 14);
    wide = ($urandom_range(0, 3) == 0);
    base = 8'($urandom);
    while (n + m > 0) begin
      if ($urandom_range(0, 39) == 0) send_item(ACT_NOP, 8'($urandom));
      if (n > 0 && (m == 0 || $urandom_range(0, 1))) begin
        send_item(ACT_SRC, wide ? 8'($urandom) : base + 8'($urandom_range(0, 2)));
        n--;
      end else begin
        send_item(ACT_TGT, wide ? 8'($urandom) : base + 8'($urandom_range(0, 2)));
        m--;
      end
    end
    send_item(ACT_RUN, 8'($urandom));
  endtask

  initial begin
    logic [LIM_W-1:0] limits[6];
    limits = '{6'd20, 6'd0, 6'd32, 6'd63, 6'd1, 6'd7};
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    action     = ACT_SRC;
    symbol     = 8'h00;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    item_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty strings, repeated-pattern target, extremes of the byte, unused action
    send_item(ACT_RUN, 8'hff);
    send_item(ACT_SRC, 8'h00);
    send_item(ACT_SRC, 8'hff);
    send_item(ACT_RUN, 8'h00);
    for (int k = 0; k < 8; k++) send_item(ACT_TGT, (k % 2) ? 8'hff : 8'h00);
    send_item(ACT_RUN, 8'h00);
    send_item(ACT_NOP, 8'h5a);
    send_item(ACT_SRC, 8'hff);
    send_item(ACT_TGT, 8'hff);
    send_item(ACT_SRC, 8'h00);
    send_item(ACT_TGT, 8'h01);
    send_item(ACT_NOP, 8'ha5);
    send_item(ACT_RUN, 8'h00);
    drain_results();

    for (int ph = 0; ph < 6; ph++) begin
      write_limit(limits[ph]);
      if (ph == 2) begin
        // full source: the last byte is dropped
        send_string(ACT_SRC, 257, 8'h40);
        send_string(ACT_TGT, 3, 8'h40);
        send_item(ACT_RUN, 8'h00);
      end
      if (ph == 4) begin
        // full target with a short source
        send_string(ACT_TGT, 258, 8'h10);
        send_string(ACT_SRC, 2, 8'h10);
        send_item(ACT_RUN, 8'h00);
      end
      while (item_count < ItemTarget * (ph + 1) / 6) send_job();
      drain_results();
    end

    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
